/* design/ufic_pkg.sv */
package ufic_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;
    localparam int WORD_W     = 9;

    localparam logic [2:0] KIND_TX_WRITE = 3'd0;
    localparam logic [2:0] KIND_RX_READ  = 3'd1;
    localparam logic [2:0] KIND_LINE_IN  = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_IRQ_CLR  = 3'd4;
    localparam logic [2:0] KIND_IRQ_SET  = 3'd5;

    localparam logic [2:0] CFG_FRAME_MODE = 3'd0;
    localparam logic [2:0] CFG_ODD_PARITY = 3'd1;
    localparam logic [2:0] CFG_RX_FIFO    = 3'd2;
    localparam logic [2:0] CFG_TX_FIFO    = 3'd3;
    localparam logic [2:0] CFG_LOOPBACK   = 3'd4;
    localparam logic [2:0] CFG_RX_ENABLE  = 3'd5;
    localparam logic [2:0] CFG_IRQ_MASK   = 3'd6;
    localparam logic [2:0] CFG_DMA_ENABLE = 3'd7;

    localparam logic [2:0] MODE_ASYNC7P  = 3'd2;
    localparam logic [2:0] MODE_ASYNC8P  = 3'd3;
    localparam logic [2:0] MODE_ASYNC9   = 3'd4;
    localparam logic [2:0] MODE_WAKEUP8  = 3'd5;

    localparam logic [7:0] IRQ_TX  = 8'h01;
    localparam logic [7:0] IRQ_TB  = 8'h02;
    localparam logic [7:0] IRQ_RX  = 8'h04;
    localparam logic [7:0] IRQ_ERR = 8'h08;

    // Command broadcast to every cell of a FIFO row.
    typedef struct packed {
        logic               push;    // store at the tail
        logic               replace; // overwrite the last slot
        logic               pop;     // shift row towards the head
        logic               clear;
        logic [WORD_W-1:0]  word;
        logic [CNT_W-1:0]   fill;    // fill before this event
        logic               deep;    // FIFO enabled
    } fifo_cmd_t;

    function automatic logic [CNT_W-1:0] clamp_level(input logic [5:0] ctl);
        logic [CNT_W-1:0] lv;
        lv = ctl[5:2];
        if (lv > CNT_W'(FIFO_DEPTH)) lv = CNT_W'(FIFO_DEPTH);
        if (lv == '0) lv = CNT_W'(1);
        return lv;
    endfunction

    function automatic logic rx_cond(input logic [5:0] ctl, input logic [CNT_W-1:0] f);
        if (ctl[0] && !ctl[1]) return f >= clamp_level(ctl);
        return f != '0;
    endfunction

    function automatic logic tb_cond(input logic [5:0] ctl, input logic [CNT_W-1:0] f);
        if (ctl[0]) begin
            if (ctl[1]) return f < CNT_W'(FIFO_DEPTH);
            return f <= clamp_level(ctl);
        end
        return f == '0;
    endfunction

    function automatic logic tx_cond(input logic [5:0] ctl, input logic [CNT_W-1:0] f);
        if (ctl[0]) begin
            if (ctl[1]) return 1'b1;
            return f <= clamp_level(ctl);
        end
        return f == '0;
    endfunction

endpackage

/* design/ufic_cell.sv */
module ufic_cell
    import ufic_pkg::*;
(
    input  logic              aclk,
    input  logic [PTR_W-1:0]  pos,
    input  fifo_cmd_t         cmd,
    input  logic [WORD_W-1:0] from_next,
    output logic [WORD_W-1:0] word
);
    // Slot 0 is always the head; a pop moves every word one slot down.
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  slot, last;

    assign slot = {1'b0, pos};
    assign last = cmd.deep ? CNT_W'(FIFO_DEPTH - 1) : '0;

    always_comb begin
        word_next = word_reg;
        if (cmd.pop) begin
            word_next = from_next;
        end else if (cmd.push && slot == cmd.fill) begin
            word_next = cmd.word;
        end else if (cmd.replace && slot == last) begin
            word_next = cmd.word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;
endmodule

/* design/ufic_fifo.sv */
module ufic_fifo
    import ufic_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  fifo_cmd_t         cmd,
    output logic [WORD_W-1:0] head_word,
    output logic [CNT_W-1:0]  fill
);
    logic [WORD_W-1:0] words [FIFO_DEPTH];
    logic [CNT_W-1:0]  fill_reg, fill_next;

    genvar g;
    generate
        for (g = 0; g < FIFO_DEPTH; g++) begin : g_cell
            ufic_cell u_cell (
                .aclk     (aclk),
                .pos      (PTR_W'(g)),
                .cmd      (cmd),
                .from_next(g == FIFO_DEPTH - 1 ? words[g] : words[(g + 1) % FIFO_DEPTH]),
                .word     (words[g])
            );
        end
    endgenerate

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear) fill_next = '0;
        else if (cmd.push) fill_next = fill_reg + 1'b1;
        else if (cmd.pop) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) fill_reg <= '0;
        else fill_reg <= fill_next;
    end

    assign head_word = words[0];
    assign fill = fill_reg;
endmodule

/* design/usart_fifo_irq_core.sv */
// Channel   | Dir | Payload (low bit first)
// s_axis    | in  | tdata: data_word[8:0], irq_bits[16:9], dma_tx_hold, dma_rx_hold; tuser: kind
// m_axis    | out | tdata: read_word, rx_count, tx_count, raw_status, masked_status,
//           |     |        overrun_flag, line_valid, line_byte, dma_tx_request, dma_rx_request
// cfg       | in  | cfg_index: register number, cfg_data: value
//
// A new event word is accepted every cycle while the output register is empty or being
// taken in the same cycle. The rate is set by the update of the FIFO cell rows. Reset is
// synchronous and active low; it empties both FIFOs and clears the flags. A stalled output
// holds its result and stalls the input.
module usart_fifo_irq_core
    import ufic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_word, irq_bits, dma_tx_hold, dma_rx_hold
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // read_word, rx_count, tx_count, raw_status,
                                       // masked_status, overrun_flag, line_valid,
                                       // line_byte, dma_tx_request, dma_rx_request
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    logic [2:0] frame_mode_reg;
    logic       odd_parity_reg, loopback_reg, rx_enable_reg;
    logic [5:0] rx_ctl_reg, tx_ctl_reg;
    logic [7:0] irq_mask_reg;
    logic [1:0] dma_en_reg;

    logic [WORD_W-1:0] holding_reg, holding_next;
    logic              sending_reg, sending_next;
    logic [7:0]        raw_reg, raw_next;
    logic              overrun_reg, overrun_next;

    logic        out_valid_reg;
    logic [47:0] out_data_reg, out_data_next;

    fifo_cmd_t         tx_cmd, rx_cmd;
    logic [WORD_W-1:0] tx_head, rx_head;
    logic [CNT_W-1:0]  tx_fill, rx_fill;

    logic        accept, cfg_we;
    logic [2:0]  kind;
    logic [8:0]  data;
    logic [7:0]  bits;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid;
    assign kind = s_axis_tuser;
    assign data = s_axis_tdata[8:0];
    assign bits = s_axis_tdata[16:9];

    ufic_fifo u_tx (.aclk(aclk), .aresetn(aresetn), .cmd(tx_cmd), .head_word(tx_head),
                    .fill(tx_fill));
    ufic_fifo u_rx (.aclk(aclk), .aresetn(aresetn), .cmd(rx_cmd), .head_word(rx_head),
                    .fill(rx_fill));

    always_comb begin
        logic [CNT_W-1:0]  txf, rxf, txcap, rxcap;
        logic [WORD_W-1:0] rd, frame, rx_word;
        logic              lv, got, rx_in;
        logic [7:0]        lb;

        holding_next = holding_reg;
        sending_next = sending_reg;
        raw_next     = raw_reg;
        overrun_next = overrun_reg;
        tx_cmd = '0;
        rx_cmd = '0;
        tx_cmd.fill = tx_fill;
        tx_cmd.deep = tx_ctl_reg[0];
        rx_cmd.fill = rx_fill;
        rx_cmd.deep = rx_ctl_reg[0];
        txf = tx_fill;
        rxf = rx_fill;
        txcap = tx_ctl_reg[0] ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
        rxcap = rx_ctl_reg[0] ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
        rd = '0;
        lv = 1'b0;
        lb = '0;
        got = 1'b0;
        rx_in = 1'b0;
        rx_word = {1'b0, data[7:0]};
        frame = {1'b0, holding_reg[7:0]};

        case (frame_mode_reg)
            MODE_ASYNC7P: frame = {1'b0, ^holding_reg[6:0] ^ odd_parity_reg,
                                   holding_reg[6:0]};
            MODE_ASYNC8P: frame = {^holding_reg[7:0] ^ odd_parity_reg, holding_reg[7:0]};
            MODE_ASYNC9, MODE_WAKEUP8: frame = holding_reg;
            default: frame = {1'b0, holding_reg[7:0]};
        endcase

        if (accept) begin
            case (kind)
                KIND_TX_WRITE: begin
                    tx_cmd.word = data;
                    if (tx_fill >= txcap) begin
                        tx_cmd.replace = 1'b1;
                        if (tx_ctl_reg[0]) begin
                            overrun_next = 1'b1;
                            raw_next = raw_next | IRQ_ERR;
                        end
                    end else if (sending_reg) begin
                        tx_cmd.push = 1'b1;
                        txf = tx_fill + 1'b1;
                        if (tb_cond(tx_ctl_reg, txf)) raw_next = raw_next | IRQ_TB;
                    end else begin
                        // Written straight through into the holding word.
                        holding_next = data;
                        sending_next = 1'b1;
                        if (tb_cond(tx_ctl_reg, txf)) raw_next = raw_next | IRQ_TB;
                    end
                end
                KIND_RX_READ: begin
                    if (rx_fill != '0) begin
                        rd = rx_head;
                        rx_cmd.pop = 1'b1;
                        rxf = rx_fill - 1'b1;
                        if (rx_ctl_reg[1] && rxf != '0) raw_next = raw_next | IRQ_RX;
                    end else begin
                        raw_next = raw_next | IRQ_ERR;
                    end
                end
                KIND_LINE_IN: begin
                    rx_in = 1'b1;
                    got = 1'b1;
                end
                KIND_TICK: begin
                    if (sending_reg) begin
                        sending_next = 1'b0;
                        lv = 1'b1;
                        lb = holding_reg[7:0];
                        if (loopback_reg && rx_enable_reg &&
                            !(frame_mode_reg == MODE_WAKEUP8 && !frame[8])) begin
                            rx_in = 1'b1;
                            rx_word = frame;
                            got = 1'b1;
                        end
                        if (tb_cond(tx_ctl_reg, tx_fill)) raw_next = raw_next | IRQ_TB;
                        if (tx_cond(tx_ctl_reg, tx_fill)) raw_next = raw_next | IRQ_TX;
                        if (tx_fill != '0) begin
                            holding_next = tx_head;
                            tx_cmd.pop = 1'b1;
                            txf = tx_fill - 1'b1;
                            sending_next = 1'b1;
                            if (tb_cond(tx_ctl_reg, txf)) raw_next = raw_next | IRQ_TB;
                        end
                    end
                end
                KIND_IRQ_CLR: raw_next = raw_next & ~bits;
                KIND_IRQ_SET: raw_next = raw_next | bits;
                default: ;
            endcase
            if (rx_in) begin
                rx_cmd.word = rx_word;
                if (rx_fill >= rxcap) begin
                    rx_cmd.replace = 1'b1;
                    overrun_next = 1'b1;
                    raw_next = raw_next | IRQ_RX | IRQ_ERR;
                end else begin
                    rx_cmd.push = 1'b1;
                    rxf = rx_fill + 1'b1;
                end
                if (got && rx_cond(rx_ctl_reg, rxf)) raw_next = raw_next | IRQ_RX;
            end
        end

        if (cfg_we && cfg_index == CFG_RX_FIFO && (cfg_data[0] ^ rx_ctl_reg[0]))
            rx_cmd.clear = 1'b1;
        if (cfg_we && cfg_index == CFG_TX_FIFO && (cfg_data[0] ^ tx_ctl_reg[0]))
            tx_cmd.clear = 1'b1;

        out_data_next = {
            3'b000,
            ~s_axis_tdata[18] & dma_en_reg[1] & rx_cond(rx_ctl_reg, rxf),
            ~s_axis_tdata[17] & dma_en_reg[0] & (txf == '0),
            lb, lv, overrun_next, raw_next & irq_mask_reg, raw_next, txf, rxf, rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg <= '0;
            odd_parity_reg <= 1'b0;
            rx_ctl_reg     <= 6'd4;
            tx_ctl_reg     <= 6'd4;
            loopback_reg   <= 1'b0;
            rx_enable_reg  <= 1'b0;
            irq_mask_reg   <= '0;
            dma_en_reg     <= '0;
            holding_reg    <= '0;
            sending_reg    <= 1'b0;
            raw_reg        <= '0;
            overrun_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            holding_reg <= holding_next;
            sending_reg <= sending_next;
            raw_reg     <= raw_next;
            overrun_reg <= overrun_next;
            if (accept) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FRAME_MODE: frame_mode_reg <= cfg_data[2:0];
                    CFG_ODD_PARITY: odd_parity_reg <= cfg_data[0];
                    CFG_RX_FIFO:    rx_ctl_reg     <= cfg_data[5:0];
                    CFG_TX_FIFO:    tx_ctl_reg     <= cfg_data[5:0];
                    CFG_LOOPBACK:   loopback_reg   <= cfg_data[0];
                    CFG_RX_ENABLE:  rx_enable_reg  <= cfg_data[0];
                    CFG_IRQ_MASK:   irq_mask_reg   <= cfg_data;
                    CFG_DMA_ENABLE: dma_en_reg     <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule
